// ===== rtl/core/eaie_pkg.sv =====
`default_nettype none
package eaie_pkg;

  // channel count: two sides times three event kinds
  localparam int unsigned NumChan = 6;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [63:0] RATE_NUM   = 64'd65536000000;
  localparam logic [63:0] SHORT_DIV  = 64'd20;
  localparam logic [63:0] LONG_DIV   = 64'd200;
  localparam logic [19:0] SHORT_MUL  = 20'd19;
  localparam logic [19:0] LONG_MUL   = 20'd199;
  localparam logic [19:0] USEC_MUL   = 20'd1000000;

  localparam logic [47:0] MAX48U     = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] SMAX48     = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] SMIN48     = 64'hFFFF_8000_0000_0000;
  localparam logic [48:0] DIFF_LIM   = 49'h0_0800_0000_0000;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/eaie_mul.sv =====
`default_nettype none
// shift-add multiplier, one multiplier bit per cycle
module eaie_mul import eaie_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] mcand,
  input  wire logic [19:0] mplier,
  output unit_stat_t       stat,
  output logic [63:0]      prod
);

  logic [63:0] a;
  logic [19:0] b;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd19;
        a    <= mcand;
        b    <= mplier;
        prod <= '0;
      end else if (busy) begin
        if (b[0]) begin
          prod <= prod + a;
        end
        a <= {a[62:0], 1'b0};
        b <= {1'b0, b[19:1]};
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule
`default_nettype wire

// ===== rtl/core/eaie_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module eaie_div import eaie_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output unit_stat_t       stat,
  output logic [63:0]      quot
);

  logic [63:0] rem;
  logic [63:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic [65:0] diff;

  assign trial = {rem, quot[63]};
  assign diff  = {1'b0, trial} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd63;
        rem  <= '0;
        quot <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!diff[65]) begin
          rem  <= diff[63:0];
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= trial[63:0];
          quot <= {quot[62:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule
`default_nettype wire

// ===== rtl/core/event_arrival_intensity_ema.sv =====
// channel | direction | handshake          | word
// in      | sink      | in_valid/in_stall   | side, func, timestamp_us
// out     | source    | out_valid/out_stall | rate_short, rate_long, rate_accel,
//         |           |                     | rate_ratio, updated
//
// an updating event runs up to six passes of the serial divider plus four passes
// of the serial multiplier (start, 64 or 20 steps, done), all in sequence, plus
// the sequencer steps between them
// a first event or a non-positive gap runs at most one divider pass (ratio pass only)
// reset clears every channel's history at once; no clearing pass
// in_stall is high from acceptance until the word is handed to the output register
// a stalled output word holds; the next event may be accepted meanwhile
`default_nettype none
module event_arrival_intensity_ema import eaie_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        side,
  input  wire logic [1:0]  func,
  input  wire logic [62:0] timestamp_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      rate_short,
  output logic [47:0]      rate_long,
  output logic [47:0]      rate_accel,
  output logic [31:0]      rate_ratio,
  output logic             updated
);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GAP   = 4'd1;
  localparam logic [3:0] S_INST  = 4'd2;
  localparam logic [3:0] S_M19   = 4'd3;
  localparam logic [3:0] S_DS    = 4'd4;
  localparam logic [3:0] S_M199  = 4'd5;
  localparam logic [3:0] S_DL    = 4'd6;
  localparam logic [3:0] S_MD    = 4'd7;
  localparam logic [3:0] S_DT    = 4'd8;
  localparam logic [3:0] S_MA    = 4'd9;
  localparam logic [3:0] S_DA    = 4'd10;
  localparam logic [3:0] S_RATIO = 4'd11;
  localparam logic [3:0] S_DR    = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  // per-channel history
  logic [62:0] last_time   [NumChan];
  logic        time_valid  [NumChan];
  logic [47:0] short_rate  [NumChan];
  logic [47:0] long_rate   [NumChan];
  logic [47:0] accel_rate  [NumChan];
  logic [31:0] ratio_value [NumChan];

  logic [3:0]  state;
  logic [2:0]  ch;
  logic        unused_kind;
  logic        upd;
  logic [62:0] ts;
  logic [63:0] gap;
  logic [63:0] inst;
  logic [47:0] s_new;
  logic [47:0] l_new;
  logic        d_neg;
  logic [63:0] term;
  logic        a_neg;

  // serial units
  logic        mul_start;
  logic [63:0] mul_a;
  logic [19:0] mul_b;
  unit_stat_t  mul_stat;
  logic [63:0] mul_p;
  logic        div_start;
  logic [63:0] div_n;
  logic [63:0] div_d;
  unit_stat_t  div_stat;
  logic [63:0] div_q;

  eaie_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(mul_a), .mplier(mul_b),
    .stat(mul_stat), .prod(mul_p)
  );

  eaie_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .stat(div_stat), .quot(div_q)
  );

  logic [63:0] gap_now;
  logic        gap_pos;
  logic [2:0]  ch_in;
  logic [47:0] sat_q48;
  logic [48:0] d_raw;
  logic [48:0] d_clamp;
  logic [48:0] d_mag;
  logic [47:0] acc_mag;
  logic [63:0] p_signed;
  logic [63:0] acc_sum;
  logic [63:0] sum_mag;
  logic [63:0] a_val;
  logic [63:0] a_sat;
  logic        load_out;

  assign ch_in   = side ? (3'd3 + {1'b0, func}) : {1'b0, func};
  assign gap_now = {1'b0, ts} - {1'b0, last_time[ch]};
  assign gap_pos = !gap_now[63] && (gap_now != 64'd0);
  // saturate an unsigned quotient to 48 bits
  assign sat_q48 = (div_q[63:48] != 16'd0) ? MAX48U : div_q[47:0];

  // change of the short average, clamped to plus or minus 2^43
  assign d_raw   = {1'b0, sat_q48} - {1'b0, short_rate[ch]};
  always_comb begin
    d_clamp = d_raw;
    if (!d_raw[48] && d_raw > DIFF_LIM) begin
      d_clamp = DIFF_LIM;
    end else if (d_raw[48] && d_raw < (49'd0 - DIFF_LIM)) begin
      d_clamp = 49'd0 - DIFF_LIM;
    end
  end
  assign d_mag   = d_clamp[48] ? (49'd0 - d_clamp) : d_clamp;

  assign acc_mag  = accel_rate[ch][47] ? (48'd0 - accel_rate[ch]) : accel_rate[ch];
  assign p_signed = accel_rate[ch][47] ? (64'd0 - mul_p) : mul_p;
  assign acc_sum  = p_signed + term;
  assign sum_mag  = acc_sum[63] ? (64'd0 - acc_sum) : acc_sum;
  // quotient truncated toward zero, sign restored
  assign a_val    = a_neg ? (64'd0 - div_q) : div_q;
  always_comb begin
    a_sat = a_val;
    if ($signed(a_val) > $signed(SMAX48)) begin
      a_sat = SMAX48;
    end else if ($signed(a_val) < $signed(SMIN48)) begin
      a_sat = SMIN48;
    end
  end

  assign load_out = (state == S_FIN) && (!out_valid || !out_stall);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      for (int i = 0; i < NumChan; i++) begin
        last_time[i]   <= '0;
        time_valid[i]  <= 1'b0;
        short_rate[i]  <= '0;
        long_rate[i]   <= '0;
        accel_rate[i]  <= '0;
        ratio_value[i] <= '0;
      end
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch          <= ch_in;
            ts          <= timestamp_us;
            unused_kind <= (func == FUNC_UNUSED);
            upd         <= 1'b0;
            state       <= (func == FUNC_UNUSED) ? S_FIN : S_GAP;
          end
        end
        S_GAP: begin
          gap               <= gap_now;
          last_time[ch]     <= ts;
          time_valid[ch]    <= 1'b1;
          if (time_valid[ch] && gap_pos) begin
            div_n     <= RATE_NUM;
            div_d     <= gap_now;
            div_start <= 1'b1;
            state     <= S_INST;
          end else begin
            state <= S_RATIO;
          end
        end
        S_INST: begin
          if (div_stat.done) begin
            inst      <= div_q;
            mul_a     <= {16'd0, short_rate[ch]};
            mul_b     <= SHORT_MUL;
            mul_start <= 1'b1;
            state     <= S_M19;
          end
        end
        S_M19: begin
          if (mul_stat.done) begin
            div_n     <= mul_p + inst;
            div_d     <= SHORT_DIV;
            div_start <= 1'b1;
            state     <= S_DS;
          end
        end
        S_DS: begin
          if (div_stat.done) begin
            s_new     <= sat_q48;
            d_neg     <= d_clamp[48];
            mul_a     <= {16'd0, long_rate[ch]};
            mul_b     <= LONG_MUL;
            mul_start <= 1'b1;
            state     <= S_M199;
          end
        end
        S_M199: begin
          if (mul_stat.done) begin
            div_n     <= mul_p + inst;
            div_d     <= LONG_DIV;
            div_start <= 1'b1;
            state     <= S_DL;
            // magnitude of the clamped change, scaled by 1e6 next
            inst      <= {15'd0, d_mag};
          end
        end
        S_DL: begin
          if (div_stat.done) begin
            l_new     <= sat_q48;
            mul_a     <= inst;
            mul_b     <= USEC_MUL;
            mul_start <= 1'b1;
            state     <= S_MD;
          end
        end
        S_MD: begin
          if (mul_stat.done) begin
            div_n     <= mul_p;
            div_d     <= gap;
            div_start <= 1'b1;
            state     <= S_DT;
          end
        end
        S_DT: begin
          if (div_stat.done) begin
            term      <= d_neg ? (64'd0 - div_q) : div_q;
            mul_a     <= {16'd0, acc_mag};
            mul_b     <= SHORT_MUL;
            mul_start <= 1'b1;
            state     <= S_MA;
          end
        end
        S_MA: begin
          if (mul_stat.done) begin
            a_neg     <= acc_sum[63];
            div_n     <= sum_mag;
            div_d     <= SHORT_DIV;
            div_start <= 1'b1;
            state     <= S_DA;
          end
        end
        S_DA: begin
          if (div_stat.done) begin
            accel_rate[ch] <= a_sat[47:0];
            short_rate[ch] <= s_new;
            long_rate[ch]  <= l_new;
            upd            <= 1'b1;
            state          <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (long_rate[ch] != 48'd0) begin
            div_n     <= {short_rate[ch], 16'd0};
            div_d     <= {16'd0, long_rate[ch]};
            div_start <= 1'b1;
            state     <= S_DR;
          end else begin
            state <= S_FIN;
          end
        end
        S_DR: begin
          if (div_stat.done) begin
            ratio_value[ch] <= (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
            state           <= S_FIN;
          end
        end
        S_FIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register, parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rate_short <= unused_kind ? 48'd0 : short_rate[ch];
      rate_long  <= unused_kind ? 48'd0 : long_rate[ch];
      rate_accel <= unused_kind ? 48'd0 : accel_rate[ch];
      rate_ratio <= unused_kind ? 32'd0 : ratio_value[ch];
      updated    <= upd;
    end
  end

  // the two serial units never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // a new output word only comes from the final step
  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("output word loaded outside final step");

  // the ratio step always sees the channel's time recorded
  a_time_recorded: assert property (@(posedge clk) disable iff (rst)
    state == S_RATIO |-> time_valid[ch])
    else $error("ratio step without recorded time");

endmodule
`default_nettype wire

// ===== sim/tb_event_arrival_intensity_ema.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_event_arrival_intensity_ema;
  import eaie_pkg::*;

  // limit channel: 0 ask, 1 bid; event kinds as the block numbers them
  localparam logic [1:0] KIND_LIMIT  = 2'd0;
  localparam logic [1:0] KIND_MARKET = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [62:0] TS_MAX = {63{1'b1}};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        side = 1'b0;
  logic [1:0]  func = 2'd0;
  logic [62:0] timestamp_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [47:0] rate_short;
  logic [47:0] rate_long;
  logic [47:0] rate_accel;
  logic [31:0] rate_ratio;
  logic        updated;

  event_arrival_intensity_ema dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .side(side), .func(func), .timestamp_us(timestamp_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .rate_short(rate_short), .rate_long(rate_long), .rate_accel(rate_accel),
    .rate_ratio(rate_ratio), .updated(updated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [47:0] short_r;
    logic [47:0] long_r;
    logic [47:0] accel_r;
    logic [31:0] ratio_r;
    logic        upd;
  } rate_word_t;

  // per-channel history kept by the predictor
  logic [62:0]        chan_last  [NumChan];
  logic               chan_seen  [NumChan];
  logic [63:0]        chan_short [NumChan];
  logic [63:0]        chan_long  [NumChan];
  logic signed [63:0] chan_accel [NumChan];
  logic [31:0]        chan_ratio [NumChan];

  rate_word_t pending_rates[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int updates_seen = 0;
  int idle_cycles = 0;

  function automatic int gap_len();
    // mostly short gaps, now and then a long one
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  function automatic rate_word_t predict_rates(logic sd, logic [1:0] fn, logic [62:0] ts);
    rate_word_t w;
    int ch;
    logic signed [63:0] gap, d, term, a;
    logic [63:0] inst, s_new, l_new, q;
    w = '0;
    if (fn == FUNC_UNUSED) return w;
    ch = sd * 3 + fn;
    if (chan_seen[ch]) begin
      gap = $signed({1'b0, ts}) - $signed({1'b0, chan_last[ch]});
      if (gap > 0) begin
        inst = RATE_NUM / gap;
        s_new = (SHORT_MUL * chan_short[ch] + inst) / SHORT_DIV;
        if (s_new > MAX48U) s_new = MAX48U;
        l_new = (LONG_MUL * chan_long[ch] + inst) / LONG_DIV;
        if (l_new > MAX48U) l_new = MAX48U;
        d = $signed(s_new) - $signed(chan_short[ch]);
        if (d > $signed({15'd0, DIFF_LIM})) d = $signed({15'd0, DIFF_LIM});
        if (d < -$signed({15'd0, DIFF_LIM})) d = -$signed({15'd0, DIFF_LIM});
        term = (d * 64'sd1000000) / gap;
        a = (64'sd19 * chan_accel[ch] + term) / 64'sd20;
        if (a > $signed(SMAX48)) a = $signed(SMAX48);
        if (a < $signed(SMIN48)) a = $signed(SMIN48);
        chan_accel[ch] = a;
        chan_short[ch] = s_new;
        chan_long[ch] = l_new;
        w.upd = 1'b1;
      end
    end
    chan_last[ch] = ts;
    chan_seen[ch] = 1'b1;
    if (chan_long[ch] != 0) begin
      q = (chan_short[ch] << 16) / chan_long[ch];
      chan_ratio[ch] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    w.short_r = chan_short[ch][47:0];
    w.long_r  = chan_long[ch][47:0];
    w.accel_r = chan_accel[ch][47:0];
    w.ratio_r = chan_ratio[ch];
    return w;
  endfunction

  // one word into the block; the prediction is made on acceptance
  // valid stays high into the next word when there is no gap
  task automatic send_event(logic sd, logic [1:0] fn, logic [62:0] ts);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    side <= sd;
    func <= fn;
    timestamp_us <= ts;
    do @(posedge clk); while (in_stall);
    pending_rates.push_back(predict_rates(sd, fn, ts));
    words_sent++;
    @(negedge clk);
  endtask

  // checker: compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    rate_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rates.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        w = pending_rates.pop_front();
        words_checked++;
        if (updated) updates_seen++;
        if (rate_short !== w.short_r) begin
          $error("rate_short exp %h got %h", w.short_r, rate_short); errors++;
        end
        if (rate_long !== w.long_r) begin
          $error("rate_long exp %h got %h", w.long_r, rate_long); errors++;
        end
        if (rate_accel !== w.accel_r) begin
          $error("rate_accel exp %h got %h", w.accel_r, rate_accel); errors++;
        end
        if (rate_ratio !== w.ratio_r) begin
          $error("rate_ratio exp %h got %h", w.ratio_r, rate_ratio); errors++;
        end
        if (updated !== w.upd) begin
          $error("updated exp %b got %b", w.upd, updated); errors++;
        end
      end
    end
  end

  // output back-pressure, with runs of no stall at all
  initial begin
    int n;
    @(negedge clk);
    out_stall <= 1'b0;
    forever begin
      if ($urandom_range(0, 5) == 0) n = 0;
      else n = gap_len();
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d words outstanding", pending_rates.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // field extremes, first events, zero and negative gaps, unused kind
  task automatic test_directed();
    send_event(1'b0, FUNC_UNUSED, TS_MAX);
    send_event(1'b0, KIND_LIMIT, '0);
    send_event(1'b0, KIND_LIMIT, '0);
    send_event(1'b0, KIND_LIMIT, 63'd1);
    send_event(1'b0, KIND_LIMIT, 63'd2);
    send_event(1'b0, KIND_LIMIT, 63'd1);
    send_event(1'b0, KIND_LIMIT, 63'd1001);
    send_event(1'b1, KIND_MARKET, 63'd5);
    send_event(1'b1, KIND_MARKET, TS_MAX);
    send_event(1'b1, KIND_MARKET, '0);
    send_event(1'b1, KIND_MARKET, 63'd100);
    send_event(1'b0, KIND_CANCEL, 63'd10);
    send_event(1'b0, KIND_CANCEL, 63'd1_000_000_010);
    send_event(1'b0, KIND_CANCEL, 63'd1_000_000_011);
    send_event(1'b1, KIND_CANCEL, TS_MAX - 63'd10);
    send_event(1'b1, KIND_CANCEL, TS_MAX);
    send_event(1'b1, FUNC_UNUSED, '0);
    send_event(1'b1, KIND_LIMIT, 63'h2AAA_AAAA_AAAA_AAAA);
    send_event(1'b1, KIND_LIMIT, 63'h5555_5555_5555_5555);
    send_event(1'b0, KIND_MARKET, 63'd7);
    send_event(1'b0, KIND_MARKET, 63'd8);
  endtask

  // bursts of ordered events per channel with gaps from 1 us to hours,
  // plus some out-of-order times, huge jumps and unused kinds
  task automatic test_random_streams(int count);
    logic [62:0] now [NumChan];
    logic [62:0] ts, step;
    logic [1:0] fn;
    logic sd;
    int ch, r;
    foreach (now[i]) now[i] = 63'($urandom_range(0, 1000));
    for (int k = 0; k < count; k++) begin
      sd = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      fn = (r < 3) ? FUNC_UNUSED : 2'($urandom_range(0, 2));
      ch = (fn == FUNC_UNUSED) ? 0 : sd * 3 + fn;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: step = 63'($urandom_range(1, 20));
        1: step = 63'($urandom_range(1, 5000));
        2: step = 63'($urandom_range(1, 2000000));
        default: step = 63'({2'($urandom_range(0, 3)), $urandom()});
      endcase
      if (r < 80) ts = now[ch] + step;
      else if (r < 87) ts = now[ch];
      else if (r < 94) ts = now[ch] - step;
      else ts = 63'({$urandom(), $urandom()});
      if (fn != FUNC_UNUSED) now[ch] = ts;
      send_event(sd, fn, ts);
    end
  endtask

  initial begin
    foreach (chan_seen[i]) begin
      chan_last[i] = '0; chan_seen[i] = 1'b0; chan_short[i] = '0;
      chan_long[i] = '0; chan_accel[i] = '0; chan_ratio[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_streams(1700);
    in_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("sent %0d event words, checked %0d results, %0d of them updating",
             words_sent, words_checked, updates_seen);
    if (errors == 0 && pending_rates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
